FILE: rtl/wgpg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and ROM functions for the wave gradient pixel generator.
// Depends on nothing; every other file imports it.
package wgpg_pkg;

	localparam int unsigned COLUMNS = 160;
	localparam int unsigned ROWS    = 128;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_TOP_ROW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_ROW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd2;

	localparam logic [6:0] TOP_ROW_RST    = 7'd50;
	localparam logic [7:0] BOTTOM_ROW_RST = 8'd110;
	localparam logic [7:0] PHASE_STEP_RST = 8'd3;

	localparam logic [7:0] BAND_GAP = 8'd10;

	typedef struct packed {
		logic       mode;
		logic [7:0] column;
		logic [6:0] row;
	} pix_t;

	typedef struct packed {
		logic        drawn;
		logic [15:0] color;
	} res_t;

	typedef struct packed {
		logic       live;
		logic [6:0] row;
		logic [7:0] y1;
		logic [7:0] y2;
	} wave_t;

	typedef struct packed {
		logic        drawn;
		logic        solid;
		logic [12:0] num;
		logic [7:0]  span;
	} band_t;

	typedef struct packed {
		logic       drawn;
		logic       solid;
		logic [5:0] idx;
	} shade_t;

	localparam logic [7:0] QSINE [65] = '{
		8'd0,   8'd3,   8'd6,   8'd9,   8'd12,  8'd16,  8'd19,  8'd22,
		8'd25,  8'd28,  8'd31,  8'd34,  8'd37,  8'd40,  8'd43,  8'd46,
		8'd49,  8'd52,  8'd55,  8'd57,  8'd60,  8'd63,  8'd66,  8'd68,
		8'd71,  8'd73,  8'd76,  8'd78,  8'd81,  8'd83,  8'd86,  8'd88,
		8'd90,  8'd92,  8'd94,  8'd97,  8'd99,  8'd101, 8'd102, 8'd104,
		8'd106, 8'd108, 8'd109, 8'd111, 8'd112, 8'd114, 8'd115, 8'd117,
		8'd118, 8'd119, 8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd124,
		8'd125, 8'd126, 8'd126, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127,
		8'd128
	};

	localparam logic [3:0] FADE_R_OFS [64] = '{
		4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd1,  4'd1,
		4'd1,  4'd1,  4'd1,  4'd2,  4'd2,  4'd2,  4'd2,  4'd2,
		4'd3,  4'd3,  4'd3,  4'd3,  4'd3,  4'd3,  4'd4,  4'd4,
		4'd4,  4'd4,  4'd4,  4'd5,  4'd5,  4'd5,  4'd5,  4'd5,
		4'd6,  4'd6,  4'd6,  4'd6,  4'd6,  4'd6,  4'd7,  4'd7,
		4'd7,  4'd7,  4'd7,  4'd8,  4'd8,  4'd8,  4'd8,  4'd8,
		4'd9,  4'd9,  4'd9,  4'd9,  4'd9,  4'd9,  4'd10, 4'd10,
		4'd10, 4'd10, 4'd10, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11
	};

	localparam logic [5:0] FADE_G_OFS [64] = '{
		6'd0,  6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,
		6'd7,  6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
		6'd14, 6'd15, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20,
		6'd21, 6'd22, 6'd23, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27,
		6'd28, 6'd29, 6'd30, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34,
		6'd35, 6'd36, 6'd37, 6'd38, 6'd38, 6'd39, 6'd40, 6'd41,
		6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd46, 6'd47, 6'd48,
		6'd49, 6'd50, 6'd51, 6'd52, 6'd53, 6'd53, 6'd54, 6'd55
	};

	function automatic logic [7:0] sine_rom(input logic [7:0] k);
		logic [6:0] m;
		logic [6:0] j;
		logic [7:0] q;
		m = k[6:0];
		j = (m <= 7'd64) ? m : 7'(8'd128 - {1'b0, m});
		q = QSINE[j];
		if (!k[7]) begin
			return 8'd127 + q;
		end
		return (q == 8'd128) ? 8'd0 : 8'd127 - q;
	endfunction

	function automatic logic [15:0] fade_rom(input logic [5:0] idx);
		logic [4:0] r5;
		logic [5:0] g6;
		logic [4:0] b5;
		r5 = 5'd20 + {1'b0, FADE_R_OFS[idx]};
		g6 = 6'd8 + FADE_G_OFS[idx];
		b5 = (idx >= 6'd34) ? 5'd31 : 5'd30;
		return {r5, g6, b5};
	endfunction

endpackage

FILE: rtl/wgpg_wave.sv
`timescale 1ns / 1ps
// Wave front end: sine lookups, weighted sums, wave top and raw band bottom.
// Three pipeline stages; uses wgpg_pkg.
module wgpg_wave import wgpg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       up_valid,
	output logic       up_ready,
	input  pix_t       up,
	input  logic [7:0] phase,
	input  logic [6:0] top_row,
	output logic       dn_valid,
	input  logic       dn_ready,
	output wave_t      dn
);

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic       live_s1, live_s2, live_s3;
	logic [6:0] row_s1, row_s2, row_s3;
	logic [7:0] sa_s1, sb_s1, sc_s1, sd_s1;
	logic [7:0] s_s2, f_s2;
	logic [7:0] y1_s3, y2_s3;

	logic [7:0]  ia, ib, ic, id;
	logic        on_canvas;
	logic [9:0]  s_sum, f_sum;
	logic [11:0] s_mul;
	logic [7:0]  y1_c;

	assign rdy_s3   = !v_s3 || dn_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	assign ia = up.column + phase;
	assign ib = {up.column[6:0], 1'b0} - phase;
	assign ic = up.column - phase;
	assign id = {up.column[6:0], 1'b0} + {phase[6:0], 1'b0};
	assign on_canvas = (11'(up.column) < 11'(COLUMNS)) && (11'(up.row) < 11'(ROWS));

	assign s_sum = {2'b0, sa_s1} + {1'b0, sa_s1, 1'b0} + {2'b0, sb_s1};
	assign f_sum = {2'b0, sc_s1} + {1'b0, sc_s1, 1'b0} + {2'b0, sd_s1};

	assign s_mul = {1'b0, s_s2, 3'b0} + {2'b0, s_s2, 2'b0};
	assign y1_c  = {1'b0, top_row} + {3'b0, s_mul[11:7]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			live_s1 <= !up.mode && on_canvas;
			row_s1  <= up.row;
			sa_s1   <= sine_rom(ia);
			sb_s1   <= sine_rom(ib);
			sc_s1   <= sine_rom(ic);
			sd_s1   <= sine_rom(id);
		end
		if (rdy_s2 && v_s1) begin
			live_s2 <= live_s1;
			row_s2  <= row_s1;
			s_s2    <= s_sum[9:2];
			f_s2    <= f_sum[9:2];
		end
		if (rdy_s3 && v_s2) begin
			live_s3 <= live_s2;
			row_s3  <= row_s2;
			y1_s3   <= y1_c;
			y2_s3   <= y1_c + BAND_GAP + {4'b0, f_s2[7:4]};
		end
	end

	assign dn_valid = v_s3;
	assign dn.live  = live_s3;
	assign dn.row   = row_s3;
	assign dn.y1    = y1_s3;
	assign dn.y2    = y2_s3;

endmodule

FILE: rtl/wgpg_band.sv
`timescale 1ns / 1ps
// Band classifier: clip the band bottom, pick solid or fade, form fade numerator.
// Two pipeline stages; uses wgpg_pkg.
module wgpg_band import wgpg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       up_valid,
	output logic       up_ready,
	input  wave_t      up,
	input  logic [7:0] bottom_row,
	output logic       dn_valid,
	input  logic       dn_ready,
	output band_t      dn
);

	logic v_s1, v_s2;
	logic rdy_s1, rdy_s2;

	logic       live_s1;
	logic [6:0] row_s1;
	logic [7:0] y1_s1, y2_s1;
	band_t      res_s2;

	logic [7:0] r8;
	logic       solid, fade;
	logic [6:0] d;

	assign rdy_s2   = !v_s2 || dn_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	assign r8    = {1'b0, row_s1};
	assign solid = (r8 >= y1_s1) && (r8 < y2_s1);
	assign fade  = (r8 >= y2_s1) && (r8 < bottom_row);
	assign d     = 7'(r8 - y2_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			live_s1 <= up.live && (up.y1 < bottom_row);
			row_s1  <= up.row;
			y1_s1   <= up.y1;
			y2_s1   <= (up.y2 > bottom_row) ? bottom_row : up.y2;
		end
		if (rdy_s2 && v_s1) begin
			res_s2.drawn <= live_s1 && (solid || fade);
			res_s2.solid <= solid;
			res_s2.num   <= {d, 6'b0} - {6'b0, d};
			res_s2.span  <= bottom_row - y2_s1;
		end
	end

	assign dn_valid = v_s2;
	assign dn       = res_s2;

endmodule

FILE: rtl/wgpg_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for the fade index, two quotient bits per stage.
// Three pipeline stages; uses wgpg_pkg.
module wgpg_div import wgpg_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   up_valid,
	output logic   up_ready,
	input  band_t  up,
	output logic   dn_valid,
	input  logic   dn_ready,
	output shade_t dn
);

	function automatic logic [13:0] div_bit(input logic [12:0] rem, input logic [12:0] dsh);
		logic ge;
		ge = (rem >= dsh);
		return {ge, ge ? rem - dsh : rem};
	endfunction

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic        drawn_s1, drawn_s2, drawn_s3;
	logic        solid_s1, solid_s2, solid_s3;
	logic [7:0]  span_s1, span_s2;
	logic [12:0] rem_s1, rem_s2;
	logic [1:0]  q_s1;
	logic [3:0]  q_s2;
	logic [5:0]  q_s3;

	logic [13:0] b5, b4, b3, b2, b1, b0;

	assign rdy_s3   = !v_s3 || dn_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	assign b5 = div_bit(up.num,    {up.span, 5'b0});
	assign b4 = div_bit(b5[12:0],  {1'b0, up.span, 4'b0});
	assign b3 = div_bit(rem_s1,    {2'b0, span_s1, 3'b0});
	assign b2 = div_bit(b3[12:0],  {3'b0, span_s1, 2'b0});
	assign b1 = div_bit(rem_s2,    {4'b0, span_s2, 1'b0});
	assign b0 = div_bit(b1[12:0],  {5'b0, span_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			drawn_s1 <= up.drawn;
			solid_s1 <= up.solid;
			span_s1  <= up.span;
			rem_s1   <= b4[12:0];
			q_s1     <= {b5[13], b4[13]};
		end
		if (rdy_s2 && v_s1) begin
			drawn_s2 <= drawn_s1;
			solid_s2 <= solid_s1;
			span_s2  <= span_s1;
			rem_s2   <= b2[12:0];
			q_s2     <= {q_s1, b3[13], b2[13]};
		end
		if (rdy_s3 && v_s2) begin
			drawn_s3 <= drawn_s2;
			solid_s3 <= solid_s2;
			q_s3     <= {q_s2, b1[13], b0[13]};
		end
	end

	assign dn_valid = v_s3;
	assign dn.drawn = drawn_s3;
	assign dn.solid = solid_s3;
	assign dn.idx   = q_s3;

endmodule

FILE: rtl/wave_gradient_pixel_generator.sv
`timescale 1ns / 1ps
// Top level: configuration registers, wave phase, pipeline and output register.
// Depends on wgpg_pkg, wgpg_wave, wgpg_band and wgpg_div.
//
//  channel | direction | handshake              | payload
//  pix     | in        | pix_valid / pix_stall  | pix_t {mode, column, row}
//  res     | out       | res_valid / res_stall  | res_t {drawn, color}
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One beat per cycle sustained while res is not stalled; nine registers from pix to res
// (3 wave stages, 2 band stages, 3 divider stages, output register), and a result
// passes through them in that order before it shows on res.
// Reset: top_row 50, bottom_row 110, phase_step 3, phase 0, pipeline empty.
// A stalled stage holds; stages behind it keep filling bubbles, so pix is taken
// while a result waits on res until the bubbles are used up. cfg is always ready.
module wave_gradient_pixel_generator import wgpg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  pix_t                 pix,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	logic [6:0] top_row_q;
	logic [7:0] bottom_row_q;
	logic [7:0] phase_step_q;
	logic [7:0] phase_q;

	logic   wave_ready, wave_valid, band_ready, band_valid, div_ready, div_valid;
	wave_t  wave;
	band_t  band;
	shade_t shade;

	logic res_v_s1;
	res_t res_s1;
	logic rdy_out;

	assign cfg_ready = 1'b1;
	assign pix_stall = !wave_ready;
	assign rdy_out   = !res_v_s1 || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_row_q    <= TOP_ROW_RST;
			bottom_row_q <= BOTTOM_ROW_RST;
			phase_step_q <= PHASE_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TOP_ROW:    top_row_q    <= cfg_data[6:0];
				CFG_BOTTOM_ROW: bottom_row_q <= cfg_data;
				CFG_PHASE_STEP: phase_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance the phase when a frame beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (pix_valid && !pix_stall && pix.mode) begin
			phase_q <= phase_q + phase_step_q;
		end
	end

	wgpg_wave u_wave (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pix_valid),
		.up_ready (wave_ready),
		.up       (pix),
		.phase    (phase_q),
		.top_row  (top_row_q),
		.dn_valid (wave_valid),
		.dn_ready (band_ready),
		.dn       (wave)
	);

	wgpg_band u_band (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (wave_valid),
		.up_ready   (band_ready),
		.up         (wave),
		.bottom_row (bottom_row_q),
		.dn_valid   (band_valid),
		.dn_ready   (div_ready),
		.dn         (band)
	);

	wgpg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (band_valid),
		.up_ready (div_ready),
		.up       (band),
		.dn_valid (div_valid),
		.dn_ready (rdy_out),
		.dn       (shade)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s1 <= 1'b0;
		end else if (rdy_out) begin
			res_v_s1 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && div_valid) begin
			res_s1.drawn <= shade.drawn;
			if (!shade.drawn) begin
				res_s1.color <= '0;
			end else if (shade.solid) begin
				res_s1.color <= fade_rom(6'd0);
			end else begin
				res_s1.color <= fade_rom(shade.idx);
			end
		end
	end

	assign res_valid = res_v_s1;
	assign res       = res_s1;

endmodule

FILE: rtl/wgpg_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the wave gradient pixel generator, bound to the top level.
// Depends on wgpg_pkg.
module wgpg_checker import wgpg_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 pix_valid,
	input logic                 pix_stall,
	input pix_t                 pix,
	input logic                 res_valid,
	input logic                 res_stall,
	input res_t                 res,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DAT_W-1:0] cfg_data
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("res beat dropped under stall");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("res payload changed under stall");

	a_blank_black: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.drawn |-> res.color == 16'd0)
		else $error("undrawn pixel carries a color");

	a_ramp_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.drawn |-> res.color[15] && res.color[4:1] == 4'hF)
		else $error("drawn color outside purple-white ramp");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid && !res_stall && !pix_stall && !cfg_valid && !pix_valid
		|=> !pix_stall)
		else $error("input stalled with empty output and no traffic");

endmodule

bind wave_gradient_pixel_generator wgpg_checker u_chk (.*);

FILE: tb/sv/tb_wave_gradient_pixel_generator.sv
`timescale 1ns / 1ps
// Self-checking bench for the wave gradient pixel generator: queued pixel and frame beats,
// a built-in wave and fade predictor, and per-field result checks under random idle and stall.
// Depends on wgpg_pkg and wave_gradient_pixel_generator.
module tb_wave_gradient_pixel_generator;
	import wgpg_pkg::*;

	localparam int IDLE_PCT = 28;
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FRAME = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	pix_t pix = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	logic calm = 1'b0;
	int mismatches = 0;
	pix_t pixel_queue[$];
	res_t expected_paint[$];
	res_t want;

	logic [6:0] top_q = TOP_ROW_RST;
	logic [7:0] bottom_q = BOTTOM_ROW_RST;
	logic [7:0] step_q = PHASE_STEP_RST;
	logic [7:0] wave_phase_q = 8'd0;

	int unsigned quarter_wave [0:64] = '{
		0, 3, 6, 9, 12, 16, 19, 22, 25, 28, 31, 34, 37, 40, 43, 46,
		49, 52, 55, 57, 60, 63, 66, 68, 71, 73, 76, 78, 81, 83, 86, 88,
		90, 92, 94, 97, 99, 101, 102, 104, 106, 108, 109, 111, 112, 114, 115, 117,
		118, 119, 120, 121, 122, 123, 124, 124, 125, 126, 126, 127, 127, 127, 127, 127,
		128
	};

	wave_gradient_pixel_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial forever #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("wave_gradient_pixel_generator regression: fail");
		$finish;
	end

	function automatic int wave_sine(int i);
		int k;
		int r;
		k = i & 255;
		if (k <= 64) return 127 + quarter_wave[k];
		if (k <= 128) return 127 + quarter_wave[128 - k];
		if (k <= 192) r = quarter_wave[k - 128];
		else r = quarter_wave[256 - k];
		return (r >= 128) ? 0 : 127 - r;
	endfunction

	function automatic logic [15:0] fade_color(int k);
		int r;
		int g;
		int b;
		r = 160 + (95 * k) / 63;
		g = 32 + (223 * k) / 63;
		b = 240 + (15 * k) / 63;
		return 16'(((r & 'hF8) << 8) | ((g & 'hFC) << 3) | (b >> 3));
	endfunction

	function automatic res_t paint_pixel(pix_t item);
		res_t paint;
		int x;
		int y;
		int p;
		int s;
		int f;
		int y1;
		int y2;
		int bot;
		paint = '0;
		x = item.column;
		y = item.row;
		p = wave_phase_q;
		bot = bottom_q;
		if (item.mode == MODE_FRAME) begin
			wave_phase_q = 8'(wave_phase_q + step_q);
			return paint;
		end
		if (x >= int'(COLUMNS) || y >= int'(ROWS)) return paint;
		s = (3 * wave_sine(x + p) + wave_sine(2 * x - p)) / 4;
		y1 = int'(top_q) + (s * 12) / 128;
		f = (3 * wave_sine(x - p) + wave_sine(2 * x + 2 * p)) / 4;
		y2 = y1 + 10 + (f * 8) / 128;
		if (y1 < bot) begin
			if (y2 > bot) y2 = bot;
			if (y >= y1 && y < y2) begin
				paint.drawn = 1'b1;
				paint.color = fade_color(0);
			end else if (y >= y2 && y < bot) begin
				paint.drawn = 1'b1;
				paint.color = fade_color(((y - y2) * 63) / (bot - y2));
			end
		end
		return paint;
	endfunction

	function automatic pix_t pixel(logic mode, int col, int row);
		pix_t item;
		item.mode = mode;
		item.column = 8'(col);
		item.row = 7'(row);
		return item;
	endfunction

	function automatic pix_t random_pixel();
		pix_t item;
		item.mode = ($urandom_range(99) < 6) ? MODE_FRAME : MODE_PIXEL;
		item.column = ($urandom_range(99) < 8) ? 8'($urandom_range(255, 160))
			: 8'($urandom_range(159));
		item.row = 7'($urandom_range(127));
		return item;
	endfunction

	// take a beat, predict it, and load the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			pix <= '0;
		end else begin
			if (pix_valid && !pix_stall)
				expected_paint.push_back(paint_pixel(pix));
			if (!pix_valid || !pix_stall) begin
				if (pixel_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					pix <= pixel_queue.pop_front();
					pix_valid <= 1'b1;
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_paint.size() == 0) begin
					$error("unexpected result beat: drawn %0d color %h", res.drawn, res.color);
					mismatches++;
				end else begin
					want = expected_paint.pop_front();
					if (res.drawn !== want.drawn) begin
						$error("drawn: expected %0d, got %0d", want.drawn, res.drawn);
						mismatches++;
					end
					if (res.color !== want.color) begin
						$error("color: expected %h, got %h", want.color, res.color);
						mismatches++;
					end
				end
			end
			res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_TOP_ROW: top_q = val[6:0];
			CFG_BOTTOM_ROW: bottom_q = val;
			CFG_PHASE_STEP: step_q = val;
			default: ;
		endcase
	endtask

	task automatic set_regs(int top, int bottom, int step);
		write_reg(CFG_TOP_ROW, 8'(top));
		write_reg(CFG_BOTTOM_ROW, 8'(bottom));
		write_reg(CFG_PHASE_STEP, 8'(step));
	endtask

	task automatic drain();
		@(negedge clk);
		while (pixel_queue.size() != 0 || pix_valid || expected_paint.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(int count, logic quiet, logic pause);
		@(negedge clk);
		calm = quiet;
		for (int i = 0; i < count; i++) begin
			pixel_queue.push_back(random_pixel());
			// hold the sender until every result is back
			if (pause && i == count / 2) drain();
		end
		drain();
		calm = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (pixel_queue[i]) ;
		pixel_queue.push_back(pixel(MODE_PIXEL, 0, 0));
		pixel_queue.push_back(pixel(MODE_PIXEL, 0, 49));
		pixel_queue.push_back(pixel(MODE_PIXEL, 0, 50));
		pixel_queue.push_back(pixel(MODE_PIXEL, 0, 60));
		pixel_queue.push_back(pixel(MODE_PIXEL, 0, 65));
		pixel_queue.push_back(pixel(MODE_PIXEL, 0, 75));
		pixel_queue.push_back(pixel(MODE_PIXEL, 0, 85));
		pixel_queue.push_back(pixel(MODE_PIXEL, 0, 100));
		pixel_queue.push_back(pixel(MODE_PIXEL, 0, 109));
		pixel_queue.push_back(pixel(MODE_PIXEL, 0, 110));
		pixel_queue.push_back(pixel(MODE_PIXEL, 0, 127));
		pixel_queue.push_back(pixel(MODE_PIXEL, 159, 70));
		pixel_queue.push_back(pixel(MODE_PIXEL, 159, 127));
		pixel_queue.push_back(pixel(MODE_PIXEL, 160, 70));
		pixel_queue.push_back(pixel(MODE_PIXEL, 255, 127));
		pixel_queue.push_back(pixel(MODE_PIXEL, 80, 55));
		pixel_queue.push_back(pixel(MODE_FRAME, 255, 127));
		pixel_queue.push_back(pixel(MODE_PIXEL, 0, 60));
		pixel_queue.push_back(pixel(MODE_PIXEL, 159, 90));
		pixel_queue.push_back(pixel(MODE_FRAME, 0, 0));
		pixel_queue.push_back(pixel(MODE_PIXEL, 37, 85));
		pixel_queue.push_back(pixel(MODE_PIXEL, 128, 106));
		drain();
		run_phase(100, 1'b0, 1'b0);

		set_regs(0, 128, 255);
		run_phase(130, 1'b0, 1'b0);

		// crest below the limit everywhere; top write carries a bit above the field
		set_regs(8'hFF, 0, 0);
		run_phase(40, 1'b0, 1'b0);

		set_regs(20, 255, 1);
		run_phase(130, 1'b0, 1'b0);

		set_regs(90, 100, 128);
		run_phase(130, 1'b0, 1'b0);

		set_regs(40, 120, 7);
		write_reg(CFG_UNUSED, 8'hC3);
		run_phase(200, 1'b1, 1'b0);

		set_regs(60, 110, 3);
		run_phase(160, 1'b0, 1'b1);

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("wave_gradient_pixel_generator regression: pass");
		else
			$display("wave_gradient_pixel_generator regression: fail");
		$finish;
	end

endmodule

FILE: wave_gradient_pixel_generator.f
rtl/wgpg_pkg.sv
rtl/wgpg_wave.sv
rtl/wgpg_band.sv
rtl/wgpg_div.sv
rtl/wave_gradient_pixel_generator.sv
rtl/wgpg_checker.sv
tb/sv/tb_wave_gradient_pixel_generator.sv
